>>> rtl/sfir_pkg.sv
// Shared constants, register codes and tap helpers for the symmetric FIR block.
// No dependencies.
`default_nettype none

package sfir_pkg;

  localparam int TAPS     = 9;
  localparam int NCOEF    = 5;
  localparam int PTR_W    = $clog2(TAPS);
  localparam int CSEL_W   = $clog2(NCOEF);
  localparam int CFG_IDX_W = 3;

  // Default datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;

  // Coefficient register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER  = 3'd0,
    CFG_SECOND = 3'd1,
    CFG_THIRD  = 3'd2,
    CFG_FOURTH = 3'd3,
    CFG_CENTER = 3'd4
  } cfg_idx_t;

  // Reset taps in Q1.15
  localparam longint COEF_RST_Q15 [NCOEF] = '{593, 1595, 4020, 6448, 7455};

  // Reset tap rescaled to a Q1.(cw-1) register
  function automatic longint coef_reset(input int idx, input int cw);
    longint v;
    v = COEF_RST_Q15[idx];
    if (cw >= 16) begin
      coef_reset = v <<< (cw - 16);
    end else begin
      coef_reset = v >>> (16 - cw);
    end
  endfunction

  // Symmetric folding: tap k uses register min(k, TAPS-1-k)
  function automatic logic [CSEL_W-1:0] tap_coef(input logic [PTR_W-1:0] k);
    logic [PTR_W-1:0] mirror;
    mirror = PTR_W'(TAPS - 1) - k;
    if (k <= PTR_W'(NCOEF - 1)) begin
      tap_coef = k[CSEL_W-1:0];
    end else begin
      tap_coef = mirror[CSEL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/symmetric_fir_9tap_filter.sv
// Top level of the nine-tap symmetric FIR filter: delay-line memory, shared MAC
// sequencer, coefficient registers and output register. Uses sfir_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one item is a signed sample plus a
//   clear_history flag. A set flag empties the whole delay line before the
//   sample is written; the write pointer still advances as usual.
//   Result channel (out_valid/out_ready): one item per input item, the rounded
//   and saturated filter output and a flag set when it was clamped.
//   Config port (cfg_we/cfg_index/cfg_data): writes one of the five Q1.x
//   coefficient registers; other indexes are ignored. Idle only.
// Timing:
//   The delay line lives in a 9-entry memory with a registered read port; one
//   tap per cycle goes through a single multiplier, and a registered product
//   feeds the accumulator. After accept the sequencer reads all nine taps
//   through the shared MAC, drains the pipeline, then rounds and saturates
//   into the output register; no new item is taken before that is done.
//   in_ready is high only while no item is in flight. If the receiver still
//   holds the previous result, the new one waits until the output register frees.
// Reset (rst_n, synchronous, active low): default taps, delay line reads as
// zeros (per-entry valid bits cleared), write pointer zero, no result pending.
`default_nettype none

module symmetric_fir_9tap_filter
  import sfir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W,
  parameter int COEF_WIDTH   = COEF_W
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // input item
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  wire                           in_clear_history,
  // result item
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_out,
  output logic                          out_saturated,
  // coefficient writes
  input  wire                           cfg_we,
  input  wire [CFG_IDX_W-1:0]           cfg_index,
  input  wire [COEF_WIDTH-1:0]          cfg_data
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int Y_W    = ACC_W - (COEF_WIDTH - 1);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (COEF_WIDTH - 2));
  localparam logic signed [Y_W-1:0]   Y_HI     = Y_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [Y_W-1:0]   Y_LO     = -Y_HI - Y_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DRAIN, S_FIN} state_t;

  state_t state_r;

  logic                    accept;
  logic [PTR_W-1:0]        wp_r;
  logic [PTR_W-1:0]        wp_nxt;
  logic [PTR_W-1:0]        rd_idx_r;
  logic [PTR_W-1:0]        k_r;
  logic [TAPS-1:0]         vld_r;
  logic [TAPS-1:0]         vld_nxt;

  // delay-line memory
  logic [SAMPLE_WIDTH-1:0] mem [TAPS];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic                    rd_ok_r;

  // pipeline
  logic                    s1_v_r, s1_last_r;
  logic                    s2_v_r, s2_last_r;
  logic [CSEL_W-1:0]       csel_r;
  logic signed [COEF_WIDTH-1:0] coef_r [NCOEF];
  logic signed [COEF_WIDTH-1:0] coef_sel;
  logic signed [SAMPLE_WIDTH-1:0] tap_val;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // round / saturate
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Y_W-1:0]    y_full;
  logic                     y_hi_sat, y_lo_sat;
  logic                     out_load;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign wp_nxt   = (wp_r == PTR_W'(TAPS - 1)) ? '0 : wp_r + PTR_W'(1);

  always_comb begin
    vld_nxt = in_clear_history ? '0 : vld_r;
    vld_nxt[wp_nxt] = 1'b1;
  end

  // Memory: write at accept, one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp_nxt] <= in_sample_in;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= COEF_WIDTH'(coef_reset(i, COEF_WIDTH));
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTER:  coef_r[0] <= cfg_data;
        CFG_SECOND: coef_r[1] <= cfg_data;
        CFG_THIRD:  coef_r[2] <= cfg_data;
        CFG_FOURTH: coef_r[3] <= cfg_data;
        CFG_CENTER: coef_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stale entries (never written since reset or clear) read as zero
  assign tap_val  = rd_ok_r ? rd_data_r : '0;
  assign coef_sel = coef_r[csel_r];

  // Datapath: multiply, then accumulate
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      prod_r <= tap_val * coef_sel;
    end
    if (accept) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc_rnd  = acc_r + RND_HALF;
  assign y_full   = acc_rnd[ACC_W-1:COEF_WIDTH-1];
  assign y_hi_sat = (y_full > Y_HI);
  assign y_lo_sat = (y_full < Y_LO);
  assign out_load = (state_r == S_FIN) && (!out_valid || out_ready);

  // Sequencer, pipeline control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rd_idx_r  <= '0;
      k_r       <= '0;
      vld_r     <= '0;
      rd_ok_r   <= 1'b0;
      csel_r    <= '0;
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // pipeline advance
      s1_v_r    <= (state_r == S_READ);
      s1_last_r <= (state_r == S_READ) && (k_r == PTR_W'(TAPS - 1));
      rd_ok_r   <= vld_r[rd_idx_r];
      csel_r    <= tap_coef(k_r);
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;

      // taken result leaves unless a new one replaces it in the same cycle
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            wp_r     <= wp_nxt;
            vld_r    <= vld_nxt;
            rd_idx_r <= wp_nxt;
            k_r      <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          // walk back from the newest sample
          rd_idx_r <= (rd_idx_r == '0) ? PTR_W'(TAPS - 1) : rd_idx_r - PTR_W'(1);
          if (k_r == PTR_W'(TAPS - 1)) begin
            k_r     <= '0;
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + PTR_W'(1);
          end
        end
        S_DRAIN: begin
          if (s2_v_r && s2_last_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_valid        <= 1'b1;
            out_saturated    <= y_hi_sat || y_lo_sat;
            out_filtered_out <= y_hi_sat ? Y_HI[SAMPLE_WIDTH-1:0] :
                                y_lo_sat ? Y_LO[SAMPLE_WIDTH-1:0] :
                                y_full[SAMPLE_WIDTH-1:0];
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Pipeline must be empty whenever a new item can enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!s1_v_r && !s2_v_r))
    else $error("MAC pipeline busy while accepting");

  // An accepted item starts the tap walk on the next cycle
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ && k_r == '0))
    else $error("tap walk did not start after accept");

  // Last product lands, then the result is finalized
  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_last_r) |=> (state_r == S_FIN))
    else $error("missing finalize after last product");

  // Newest sample is always marked present after accept
  a_new_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r[wp_r])
    else $error("written delay-line entry not marked valid");

  // Tap counter stays within the line
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= PTR_W'(TAPS - 1))
    else $error("tap counter out of range");

endmodule

`default_nettype wire
